/* rtl/textured_wall_column_shader_macros.svh */
// assertion macros used by the shader top level
`ifndef TEXTURED_WALL_COLUMN_SHADER_MACROS_SVH
`define TEXTURED_WALL_COLUMN_SHADER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every rising edge out of reset
`define TWCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shader assertion failed");

// next-cycle implication, checked on every rising edge out of reset
`define TWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shader assertion failed");

`else

`define TWCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/twcs_pkg.sv */
// shared constants and codes for the textured wall column shader
package twcs_pkg;

    // parameter defaults
    localparam int TEX_SIDE_MAX_DEF    = 64;
    localparam int SCREEN_ROWS_MAX_DEF = 2048;

    // beat field widths
    localparam int OPCODE_W = 1;
    localparam int HEIGHT_W = 12;
    localparam int SHADE_W  = 16;
    localparam int FACE_W   = 2;
    localparam int ROW_W    = 11;
    localparam int TIDX_W   = 12;
    localparam int RGB_W    = 24;
    localparam int ALPHA_W  = 8;
    localparam int RGBA_W   = RGB_W + ALPHA_W;

    // configuration register widths
    localparam int ROWS_W     = 12;
    localparam int TEX_SIZE_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // signed width for the wall top arithmetic
    localparam int FAC_W = HEIGHT_W + 2;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_RENDER = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL_COLOUR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_COLS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_ROWS      = 3'd4;

    // register reset values
    localparam logic [ROWS_W-1:0]     SCREEN_ROWS_RST = 12'd480;
    localparam logic [RGB_W-1:0]      COLOUR_RST      = 24'h000000;
    localparam logic [TEX_SIZE_W-1:0] TEX_SIZE_RST    = 7'd64;

    // pixel alpha and the rounding threshold of the texel column
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [SHADE_W-1:0] ROUND_HALF   = 16'h8000;

endpackage

/* rtl/twcs_in_if.sv */
// input channel: texel write and pixel render beats
interface twcs_in_if;

    logic                             valid;
    logic                             ready;
    logic [twcs_pkg::OPCODE_W-1:0]    opcode;
    logic [twcs_pkg::HEIGHT_W-1:0]    wall_height;
    logic [twcs_pkg::SHADE_W-1:0]     wall_shade;
    logic [twcs_pkg::FACE_W-1:0]      wall_face;
    logic [twcs_pkg::ROW_W-1:0]       screen_row;
    logic [twcs_pkg::TIDX_W-1:0]      texel_index;
    logic [twcs_pkg::RGB_W-1:0]       texel_rgb;

    modport source
    (
        output valid, opcode, wall_height, wall_shade, wall_face,
               screen_row, texel_index, texel_rgb,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, wall_height, wall_shade, wall_face,
               screen_row, texel_index, texel_rgb,
        output ready
    );

endinterface

/* rtl/twcs_out_if.sv */
// output channel: shaded pixel beats
interface twcs_out_if;

    logic                           valid;
    logic                           ready;
    logic [twcs_pkg::RGBA_W-1:0]    pixel_rgba;

    modport source
    (
        output valid, pixel_rgba,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_rgba,
        output ready
    );

endinterface

/* rtl/twcs_ram.sv */
// generic simple dual-port ram with registered read
module twcs_ram #(
    parameter int WIDTH = twcs_pkg::RGB_W,
    parameter int DEPTH = 4 * twcs_pkg::TEX_SIDE_MAX_DEF * twcs_pkg::TEX_SIDE_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/twcs_div.sv */
// pipelined restoring divider, one quotient bit per stage
module twcs_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = twcs_pkg::HEIGHT_W,
    parameter int QUO_W = 6
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic [NUM_W-1:0] rem,
    output logic [DEN_W-1:0] den_out
);

    // the numerator must stay below den * 2**QUO_W
    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            logic [NUM_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W-1:0] den_in;
            logic [NUM_W:0]   trial;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // trial subtract of the shifted divisor for bit QUO_W-1-k
            always_comb
            begin
                trial = {1'b0, rem_in} - ((NUM_W+1)'(den_in) << (QUO_W - 1 - k));
                if (!trial[NUM_W])
                begin
                    rem_next = trial[NUM_W-1:0];
                    quo_next = quo_in | (QUO_W'(1) << (QUO_W - 1 - k));
                end
                else
                begin
                    rem_next = rem_in;
                    quo_next = quo_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo     = quo_reg[QUO_W-1];
    assign rem     = rem_reg[QUO_W-1];
    assign den_out = den_reg[QUO_W-1];

endmodule

/* rtl/textured_wall_column_shader.sv */
// top level of the textured wall column shader
// Shades one screen pixel per render beat and stores one texel per write beat, taking one
// beat every clock while the output side accepts. A beat passes through the wall test,
// the column and row products, the texel row divider, which resolves one quotient bit
// per stage, row rounding and clamp, texel index forming, the registered texture store
// read and the output register. Write beats travel the same pipeline, so a render beat
// always sees every texel written before it; they hold a pipeline slot but produce no
// output beat. The texture store is not cleared after reset: a texel must be written
// before it is read. Configuration registers may be written only while the pipeline is
// empty.
`include "textured_wall_column_shader_macros.svh"

module textured_wall_column_shader #(
    parameter int TEX_SIDE_MAX    = twcs_pkg::TEX_SIDE_MAX_DEF,
    parameter int SCREEN_ROWS_MAX = twcs_pkg::SCREEN_ROWS_MAX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [twcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    twcs_in_if.sink                             item,
    twcs_out_if.source                          pixel
);

    localparam int SIDE_W      = $clog2(TEX_SIDE_MAX + 1);
    localparam int QUO_W       = $clog2(TEX_SIDE_MAX);
    localparam int NUM_W       = SIDE_W + twcs_pkg::HEIGHT_W;
    localparam int PROD_W      = SIDE_W + twcs_pkg::SHADE_W;
    localparam int TEX_AREA    = TEX_SIDE_MAX * TEX_SIDE_MAX;
    localparam int IDX_W       = $clog2(TEX_AREA);
    localparam int STORE_DEPTH = (1 << twcs_pkg::FACE_W) * TEX_AREA;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROWS_EFF_W  = twcs_pkg::ROWS_W + 1;
    localparam int FAC_W       = twcs_pkg::FAC_W;

    typedef struct packed {
        logic                               render;
        logic [twcs_pkg::FACE_W-1:0]        face;
        logic                               in_wall;
        logic                               below_mid;
        logic                               tidx_ok;
        logic [twcs_pkg::TIDX_W-1:0]        tidx;
        logic [twcs_pkg::RGB_W-1:0]         trgb;
        logic [SIDE_W-1:0]                  col;
    } ctx_t;

    // configuration registers
    logic [twcs_pkg::ROWS_W-1:0]     screen_rows_reg;
    logic [twcs_pkg::RGB_W-1:0]      floor_colour_reg;
    logic [twcs_pkg::RGB_W-1:0]      ceiling_colour_reg;
    logic [twcs_pkg::TEX_SIZE_W-1:0] tex_cols_reg;
    logic [twcs_pkg::TEX_SIZE_W-1:0] tex_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg    <= twcs_pkg::SCREEN_ROWS_RST;
            floor_colour_reg   <= twcs_pkg::COLOUR_RST;
            ceiling_colour_reg <= twcs_pkg::COLOUR_RST;
            tex_cols_reg       <= twcs_pkg::TEX_SIZE_RST;
            tex_rows_reg       <= twcs_pkg::TEX_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                twcs_pkg::REG_SCREEN_ROWS:
                    screen_rows_reg <= cfg_data[twcs_pkg::ROWS_W-1:0];
                twcs_pkg::REG_FLOOR_COLOUR:
                    floor_colour_reg <= cfg_data[twcs_pkg::RGB_W-1:0];
                twcs_pkg::REG_CEIL_COLOUR:
                    ceiling_colour_reg <= cfg_data[twcs_pkg::RGB_W-1:0];
                twcs_pkg::REG_TEX_COLS:
                    tex_cols_reg <= cfg_data[twcs_pkg::TEX_SIZE_W-1:0];
                twcs_pkg::REG_TEX_ROWS:
                    tex_rows_reg <= cfg_data[twcs_pkg::TEX_SIZE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturated sizes
    logic [SIDE_W-1:0]     cols_eff;
    logic [SIDE_W-1:0]     trows_eff;
    logic [ROWS_EFF_W-1:0] rows_eff;

    always_comb
    begin
        if (tex_cols_reg == '0)
            cols_eff = SIDE_W'(1);
        else if (32'(tex_cols_reg) > TEX_SIDE_MAX)
            cols_eff = SIDE_W'(TEX_SIDE_MAX);
        else
            cols_eff = SIDE_W'(tex_cols_reg);

        if (tex_rows_reg == '0)
            trows_eff = SIDE_W'(1);
        else if (32'(tex_rows_reg) > TEX_SIDE_MAX)
            trows_eff = SIDE_W'(TEX_SIDE_MAX);
        else
            trows_eff = SIDE_W'(tex_rows_reg);

        if (32'(screen_rows_reg) > SCREEN_ROWS_MAX)
            rows_eff = ROWS_EFF_W'(SCREEN_ROWS_MAX);
        else
            rows_eff = ROWS_EFF_W'(screen_rows_reg);
    end

    // pipeline moves whenever the output register is free or being taken
    logic pixel_valid_reg;
    logic advance;

    assign advance    = !pixel_valid_reg || pixel.ready;
    assign item.ready = advance;

    // stage 1: wall top, wall test and floor/ceiling side
    logic signed [FAC_W-1:0] diff;
    logic signed [FAC_W-1:0] half_sum;
    logic signed [FAC_W-1:0] fac;
    logic signed [FAC_W-1:0] ypos;
    logic signed [FAC_W-1:0] wall_end;
    ctx_t                               ctx1_next;
    logic [twcs_pkg::HEIGHT_W-1:0]      dist1_next;

    always_comb
    begin
        diff     = $signed(FAC_W'(rows_eff)) - $signed(FAC_W'(item.wall_height));
        half_sum = diff + $signed(FAC_W'(diff[FAC_W-1]));
        fac      = {half_sum[FAC_W-1], half_sum[FAC_W-1:1]};
        ypos     = $signed(FAC_W'(item.screen_row));
        wall_end = fac + $signed(FAC_W'(item.wall_height));

        ctx1_next.render    = (item.opcode == twcs_pkg::OP_RENDER);
        ctx1_next.face      = item.wall_face;
        ctx1_next.in_wall   = (ypos > fac) && (ypos < wall_end);
        ctx1_next.below_mid = ROWS_EFF_W'({item.screen_row, 1'b0}) > rows_eff;
        ctx1_next.tidx_ok   = 32'(item.texel_index) < TEX_AREA;
        ctx1_next.tidx      = item.texel_index;
        ctx1_next.trgb      = item.texel_rgb;
        ctx1_next.col       = '0;
        dist1_next          = twcs_pkg::HEIGHT_W'(ypos - fac);
    end

    logic                           v1_reg;
    ctx_t                           ctx1_reg;
    logic [twcs_pkg::HEIGHT_W-1:0]  h1_reg;
    logic [twcs_pkg::SHADE_W-1:0]   shade1_reg;
    logic [twcs_pkg::HEIGHT_W-1:0]  dist1_reg;

    // stage 2: texel column and row products
    logic [PROD_W-1:0] p2_next;
    logic [NUM_W-1:0]  n2_next;

    assign p2_next = cols_eff * shade1_reg;
    assign n2_next = trows_eff * dist1_reg;

    logic                           v2_reg;
    ctx_t                           ctx2_reg;
    logic [twcs_pkg::HEIGHT_W-1:0]  h2_reg;
    logic [PROD_W-1:0]              p2_reg;
    logic [NUM_W-1:0]               n2_reg;

    // texel column rounding, enters the divider stages alongside the row
    logic [SIDE_W-1:0] col_floor;
    logic              col_up;
    logic [SIDE_W-1:0] col_round;
    ctx_t              ctx3_next;

    always_comb
    begin
        col_floor = p2_reg[PROD_W-1:twcs_pkg::SHADE_W];
        col_up    = p2_reg[twcs_pkg::SHADE_W-1:0] > twcs_pkg::ROUND_HALF;
        col_round = col_floor + SIDE_W'(col_up);
        ctx3_next = ctx2_reg;
        if (col_round > cols_eff - SIDE_W'(1))
            ctx3_next.col = cols_eff - SIDE_W'(1);
        else
            ctx3_next.col = col_round;
    end

    // divider stages: row quotient and remainder
    logic [QUO_W-1:0]              div_quo;
    logic [NUM_W-1:0]              div_rem;
    logic [twcs_pkg::HEIGHT_W-1:0] div_den;

    twcs_div #(
        .NUM_W (NUM_W),
        .DEN_W (twcs_pkg::HEIGHT_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk     (clk),
        .en      (advance),
        .num     (n2_reg),
        .den     (h2_reg),
        .quo     (div_quo),
        .rem     (div_rem),
        .den_out (div_den)
    );

    logic [QUO_W-1:0] vd_reg;
    ctx_t             ctxd_reg [QUO_W];

    // stage r: row rounding and clamp
    logic              rnd_up;
    logic [SIDE_W-1:0] r_round;
    logic [SIDE_W-1:0] r_next;

    always_comb
    begin
        rnd_up  = {div_rem, 1'b0} > (NUM_W+1)'(div_den);
        r_round = SIDE_W'(div_quo) + SIDE_W'(rnd_up);
        if (r_round > trows_eff - SIDE_W'(1))
            r_next = trows_eff - SIDE_W'(1);
        else
            r_next = r_round;
    end

    logic              vr_reg;
    ctx_t              ctxr_reg;
    logic [SIDE_W-1:0] r_reg;

    // stage a: texel index within the face
    logic [2*SIDE_W-1:0] idx_prod;
    logic [2*SIDE_W:0]   idx_sum;
    logic [IDX_W-1:0]    idx_next;

    always_comb
    begin
        idx_prod = r_reg * cols_eff;
        idx_sum  = (2*SIDE_W+1)'(idx_prod) + (2*SIDE_W+1)'(ctxr_reg.col);
        if (ctxr_reg.render)
            idx_next = IDX_W'(idx_sum);
        else
            idx_next = IDX_W'(ctxr_reg.tidx);
    end

    logic             va_reg;
    ctx_t             ctxa_reg;
    logic [IDX_W-1:0] idx_reg;

    // texture store access: write beats with an index inside the face store, render beats read
    logic [ADDR_W-1:0]             face_base;
    logic [ADDR_W-1:0]             ram_addr;
    logic                          ram_we;
    logic [twcs_pkg::RGB_W-1:0]    ram_rdata;

    assign face_base = ADDR_W'(ctxa_reg.face) * ADDR_W'(TEX_AREA);
    assign ram_addr  = face_base + ADDR_W'(idx_reg);
    assign ram_we    = advance && va_reg && !ctxa_reg.render && ctxa_reg.tidx_ok;

    twcs_ram #(
        .WIDTH (twcs_pkg::RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ctxa_reg.trgb),
        .re    (advance),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    logic vb_reg;
    ctx_t ctxb_reg;

    // output stage: colour select and alpha
    logic [twcs_pkg::RGB_W-1:0]  rgb_sel;
    logic [twcs_pkg::RGBA_W-1:0] pixel_rgba_reg;

    always_comb
    begin
        if (ctxb_reg.in_wall)
            rgb_sel = ram_rdata;
        else if (ctxb_reg.below_mid)
            rgb_sel = floor_colour_reg;
        else
            rgb_sel = ceiling_colour_reg;
    end

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            vd_reg          <= '0;
            vr_reg          <= 1'b0;
            va_reg          <= 1'b0;
            vb_reg          <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg          <= item.valid;
            v2_reg          <= v1_reg;
            vd_reg          <= {vd_reg[QUO_W-2:0], v2_reg};
            vr_reg          <= vd_reg[QUO_W-1];
            va_reg          <= vr_reg;
            vb_reg          <= va_reg;
            pixel_valid_reg <= vb_reg && ctxb_reg.render;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctx1_reg   <= ctx1_next;
            h1_reg     <= item.wall_height;
            shade1_reg <= item.wall_shade;
            dist1_reg  <= dist1_next;

            ctx2_reg   <= ctx1_reg;
            h2_reg     <= h1_reg;
            p2_reg     <= p2_next;
            n2_reg     <= n2_next;

            ctxd_reg[0] <= ctx3_next;
            for (int k = 1; k < QUO_W; k++)
            begin
                ctxd_reg[k] <= ctxd_reg[k-1];
            end

            ctxr_reg <= ctxd_reg[QUO_W-1];
            r_reg    <= r_next;

            ctxa_reg <= ctxr_reg;
            idx_reg  <= idx_next;

            ctxb_reg <= ctxa_reg;

            pixel_rgba_reg <= {rgb_sel, twcs_pkg::ALPHA_OPAQUE};
        end
    end

    assign pixel.valid      = pixel_valid_reg;
    assign pixel.pixel_rgba = pixel_rgba_reg;

    // a stall freezes every beat in flight
    `TWCS_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance,
        $stable({v1_reg, v2_reg, vd_reg, vr_reg, va_reg, vb_reg, pixel_valid_reg}))

    // clamped texel row and column stay inside the texture
    `TWCS_ASSERT_SAME(a_row_in_tex, clk, rst_n, vr_reg && ctxr_reg.render && ctxr_reg.in_wall,
        r_reg < trows_eff)
    `TWCS_ASSERT_SAME(a_col_in_tex, clk, rst_n, vr_reg && ctxr_reg.render && ctxr_reg.in_wall,
        ctxr_reg.col < cols_eff)

    // a write beat leaving the last stage gives no pixel
    `TWCS_ASSERT_NEXT(a_write_no_pixel, clk, rst_n, advance && vb_reg && !ctxb_reg.render,
        !pixel_valid_reg)

endmodule
